### hdl/ldpcep_pkg.sv
// Package for the erasure peeling decoder: field widths, defaults and the parity-check rows.
package ldpcep_pkg;

   // Width of the item fields on the ports
   localparam int FIELD_WIDTH = 12;

   // Largest code supported by the row table
   localparam int MAX_LENGTH = 64;
   localparam int MAX_CHECKS = 64;

   // Defaults for the top level parameters
   localparam int DEF_CODE_LENGTH = 12;
   localparam int DEF_CHECK_COUNT = 9;
   localparam int DEF_ROUNDS      = 12;

   // Parity-check rows as position masks, bit i = position i; unused rows are empty
   localparam logic [MAX_LENGTH-1:0] CHECK_ROWS [MAX_CHECKS] = '{
      0: 64'h2A1,   // positions 0 5 7 9
      1: 64'h419,   // positions 0 3 4 10
      2: 64'h152,   // positions 1 4 6 8
      3: 64'hC24,   // positions 2 5 10 11
      4: 64'h8C4,   // positions 2 6 7 11
      5: 64'h512,   // positions 1 4 8 10
      6: 64'h249,   // positions 0 3 6 9
      7: 64'h2A2,   // positions 1 5 7 9
      8: 64'h90C,   // positions 2 3 8 11
      default: 64'h0
   };

endpackage

### hdl/ldpc_erasure_peeling_decoder_top.sv
// Top level of the LDPC erasure peeling decoder: one pipeline stage per decoding round.
module ldpc_erasure_peeling_decoder_top
   import ldpcep_pkg::*;
#(
   parameter int CODE_LENGTH = DEF_CODE_LENGTH,
   parameter int CHECK_COUNT = DEF_CHECK_COUNT,
   parameter int ROUNDS      = DEF_ROUNDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [FIELD_WIDTH-1:0] req_received_bits,
   input  logic [FIELD_WIDTH-1:0] req_erased_mask,
   output logic                   rsp_valid,
   output logic [FIELD_WIDTH-1:0] rsp_decoded_bits,
   output logic [FIELD_WIDTH-1:0] rsp_unresolved_mask,
   output logic                   rsp_all_resolved
);

   // The decoder takes an item (received word plus erasure mask) at every clock edge where
   // start is high and busy is low; busy is high only during reset. Each round of peeling
   // is one register stage behind the entry register, so an item passes the entry register and
   // then every round register before its single result shows, and a new item may enter every cycle.
   // The result shows for exactly one cycle with rsp_valid high and must be taken then:
   // there is no way to hold it off, and nothing in the block waits on the receiver.

   localparam int EXT_WIDTH = (CODE_LENGTH > FIELD_WIDTH) ? CODE_LENGTH : FIELD_WIDTH;

   // Per-stage state: valid bit, known positions, values of known positions
   logic                   valid_ff [ROUNDS+1];
   logic [CODE_LENGTH-1:0] known_ff [ROUNDS+1];
   logic [CODE_LENGTH-1:0] value_ff [ROUNDS+1];
   logic                   valid_in [ROUNDS+1];
   logic [CODE_LENGTH-1:0] known_in [ROUNDS+1];
   logic [CODE_LENGTH-1:0] value_in [ROUNDS+1];

   // Input and output fields widened to cover both the code and the port width
   logic [EXT_WIDTH-1:0]   rx_ext;
   logic [EXT_WIDTH-1:0]   erased_ext;
   logic [EXT_WIDTH-1:0]   dec_ext;
   logic [EXT_WIDTH-1:0]   unres_ext;
   logic [CODE_LENGTH-1:0] unres_full;

   assign busy = reset;

   // Entry stage: positions above the port width are never erased and read as zero
   assign rx_ext     = EXT_WIDTH'(req_received_bits);
   assign erased_ext = EXT_WIDTH'(req_erased_mask);

   always_comb begin
      valid_in[0] = start && !busy;
      known_in[0] = ~erased_ext[CODE_LENGTH-1:0];
      value_in[0] = rx_ext[CODE_LENGTH-1:0] & ~erased_ext[CODE_LENGTH-1:0];
   end

   // One peeling round per stage
   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      logic [CODE_LENGTH-1:0] res_known;
      logic [CODE_LENGTH-1:0] res_value;
      logic [CODE_LENGTH-1:0] row;
      logic [CODE_LENGTH-1:0] ers;

      // Checks walked from high to low index so the lowest check wins a shared position
      always_comb begin
         res_known = '0;
         res_value = '0;
         row       = '0;
         ers       = '0;
         for (int c = CHECK_COUNT - 1; c >= 0; c--) begin
            row = CHECK_ROWS[c][CODE_LENGTH-1:0];
            ers = row & ~known_ff[r];
            if (ers != '0 && (ers & (ers - CODE_LENGTH'(1))) == '0) begin
               res_known = res_known | ers;
               if (^(value_ff[r] & row)) begin
                  res_value = res_value | ers;
               end else begin
                  res_value = res_value & ~ers;
               end
            end
         end
         valid_in[r+1] = valid_ff[r];
         known_in[r+1] = known_ff[r] | res_known;
         value_in[r+1] = value_ff[r] | res_value;
      end
   end

   // Stage registers: valid bits reset, payload does not
   for (genvar s = 0; s <= ROUNDS; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         known_ff[s] <= known_in[s];
         value_ff[s] <= value_in[s];
      end
   end

   // Result formatting from the last stage
   assign unres_full = ~known_ff[ROUNDS];
   assign dec_ext    = EXT_WIDTH'(value_ff[ROUNDS] & known_ff[ROUNDS]);
   assign unres_ext  = EXT_WIDTH'(unres_full);

   assign rsp_valid           = valid_ff[ROUNDS];
   assign rsp_decoded_bits    = dec_ext[FIELD_WIDTH-1:0];
   assign rsp_unresolved_mask = unres_ext[FIELD_WIDTH-1:0];
   assign rsp_all_resolved    = (unres_full == '0);

   // An accepted item comes out at the end of the pipeline with rsp_valid high
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ROUNDS+1) rsp_valid)
      else $error("accepted item did not produce a result on time");

   // Decoded ones only at resolved positions
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_decoded_bits & rsp_unresolved_mask) == '0)
      else $error("decoded one at an unresolved position");

   // A position never becomes erased that was not erased on input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unresolved_mask & ~$past(req_erased_mask, ROUNDS+1)) == '0)
      else $error("unresolved position that was not erased on input");

endmodule
